FILE: rtl/core/tcr_pkg.sv
// Shared types, character codes and scaling constants of the temperature
// command responder. No dependencies; all files but tcr_channels.sv import it.
`timescale 1ns / 1ps

package tcr_pkg;

   localparam int CODE_W = 16;
   localparam int CHAR_W = 8;
   localparam int MILLI_W = 18;
   localparam int MULT_W = 20;
   localparam int PROD_W = 33;
   localparam int PREFIX_DEPTH = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [16:0] SCALE = 17'd106500;
   localparam int SCALE_SHIFT = 15;

   localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_O = 8'h6F;
   localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_T = 8'h74;
   localparam logic [CHAR_W-1:0] CHAR_E = 8'h65;
   localparam logic [CHAR_W-1:0] CHAR_M = 8'h6D;
   localparam logic [CHAR_W-1:0] CHAR_P = 8'h70;

   // Front to queue: one query to store.
   typedef struct packed {
      logic                push;
      logic [CODE_W-1:0]   adc_code;
   } cmd_type;

   // Queue fill status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Decimal weight of the digit produced at conversion step 0 to 4.
   function automatic logic [MULT_W-1:0] step_weight(input logic [2:0] step);
      logic [MULT_W-1:0] w;
      case (step)
         3'd0:    w = 20'd100000;
         3'd1:    w = 20'd10000;
         3'd2:    w = 20'd1000;
         3'd3:    w = 20'd100;
         3'd4:    w = 20'd10;
         default: w = 20'd1;
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/tcr_channels.sv
// Valid/ready channel interfaces of the temperature command responder:
// received bytes in, reply characters out. Depends on nothing.
`timescale 1ns / 1ps

interface tcr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [15:0] adc_code;
   modport source (output valid, output rx_byte, output adc_code, input ready);
   modport sink (input valid, input rx_byte, input adc_code, output ready);
endinterface

interface tcr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_char;
   logic       last;
   modport source (output valid, output tx_char, output last, input ready);
   modport sink (input valid, input tx_char, input last, output ready);
endinterface

FILE: rtl/core/tcr_front.sv
// Line collector: accepts received bytes, keeps the line prefix and count,
// and queues a query on a matching line end. Uses tcr_pkg and tcr_req_if.
`timescale 1ns / 1ps

module tcr_front #(
   parameter int LINE_LEN = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   tcr_req_if.sink               req_ch,
   input  tcr_pkg::q_status_type q_stat,
   output tcr_pkg::cmd_type      cmd
);
   import tcr_pkg::*;

   localparam int CW = $clog2(LINE_LEN);
   localparam logic [CW-1:0] MAX_COUNT = CW'(LINE_LEN - 1);
   localparam logic [CW-1:0] PREFIX_COUNT = CW'(PREFIX_DEPTH);

   logic [CW-1:0]     count_ff, count_in;
   logic [CHAR_W-1:0] prefix_ff [PREFIX_DEPTH];
   logic              accept, line_end, match;

   assign req_ch.ready = !q_stat.full;
   assign accept = req_ch.valid && req_ch.ready;
   assign line_end = (req_ch.rx_byte inside {CHAR_CR, CHAR_LF});
   assign match = (count_ff >= PREFIX_COUNT) && (prefix_ff[0] == CHAR_T) &&
                  (prefix_ff[1] == CHAR_E) && (prefix_ff[2] == CHAR_M) &&
                  (prefix_ff[3] == CHAR_P);

   assign cmd.push = accept && line_end && match;
   assign cmd.adc_code = req_ch.adc_code;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (line_end) begin
            count_in = '0;
         end else if (count_ff < MAX_COUNT) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Only the first four characters of a line are kept.
   always_ff @(posedge clock) begin
      if (accept && !line_end && (count_ff < MAX_COUNT) && (count_ff < PREFIX_COUNT)) begin
         prefix_ff[count_ff[1:0]] <= req_ch.rx_byte;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("line count beyond its limit");
`endif

endmodule

FILE: rtl/core/tcr_queue.sv
// Two-entry queue of pending temperature queries between the line collector
// and the reply generator. Uses tcr_pkg.
`timescale 1ns / 1ps

module tcr_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  tcr_pkg::cmd_type              cmd,
   input  logic                          pop,
   output tcr_pkg::q_status_type         q_stat,
   output logic [tcr_pkg::CODE_W-1:0]    head_code
);
   import tcr_pkg::*;

   logic [CODE_W-1:0] mem_ff [QUEUE_DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   assign q_stat.full = (fill_ff == 2'(QUEUE_DEPTH));
   assign q_stat.empty = (fill_ff == 2'd0);
   assign head_code = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ cmd.push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in = fill_ff + 2'(cmd.push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem_ff[wr_ptr_ff] <= cmd.adc_code;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && q_stat.full))
      else $error("query pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_stat.empty))
      else $error("query popped from an empty queue");
`endif

endmodule

FILE: rtl/core/tcr_back.sv
// Reply generator: scales a queued ADC code to millidegrees, splits it into
// decimal digits one per cycle and sends the ASCII reply. Uses tcr_pkg, tcr_rsp_if.
`timescale 1ns / 1ps

module tcr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tcr_pkg::q_status_type      q_stat,
   input  logic [tcr_pkg::CODE_W-1:0] head_code,
   output logic                       pop,
   tcr_rsp_if.source                  rsp_ch
);
   import tcr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_CONV = 4'b0100,
      ST_SEND = 4'b1000
   } state_type;

   // Reply character positions; the reply starts at the first nonzero
   // whole-degree digit, never later than the units digit.
   localparam logic [3:0] POS_HUNDREDS = 4'd0;
   localparam logic [3:0] POS_TENS = 4'd1;
   localparam logic [3:0] POS_UNITS = 4'd2;
   localparam logic [3:0] POS_DOT = 4'd3;
   localparam logic [3:0] POS_FRAC0 = 4'd4;
   localparam logic [3:0] POS_FRAC1 = 4'd5;
   localparam logic [3:0] POS_FRAC2 = 4'd6;
   localparam logic [3:0] POS_O = 4'd7;
   localparam logic [3:0] POS_C = 4'd8;
   localparam logic [3:0] POS_CR = 4'd9;
   localparam logic [3:0] POS_LF = 4'd10;
   localparam logic [2:0] LAST_STEP = 3'd4;
   localparam logic [2:0] TOP_DIGIT = 3'd5;

   state_type         state_ff, state_in;
   logic [CODE_W-1:0] code_ff;
   logic [MILLI_W-1:0] milli_ff, milli_in;
   logic [2:0]        step_ff, step_in;
   logic [3:0]        dig_ff [6];
   logic [3:0]        idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] tx_char_ff;
   logic              last_ff;

   logic [PROD_W-1:0] product;
   logic [MULT_W-1:0] weight, sub_val;
   logic [MULT_W-1:0] milli_ext;
   logic [3:0]        digit;
   logic [2:0]        dig_sel;
   logic              load;
   logic [CHAR_W-1:0] next_char;

   assign product = PROD_W'(code_ff) * PROD_W'(SCALE);
   assign weight = step_weight(step_ff);
   assign milli_ext = MULT_W'(milli_ff);
   assign dig_sel = TOP_DIGIT - step_ff;

   // The digit is the number of weight multiples that fit in the remainder.
   always_comb begin
      digit = 4'd0;
      for (int d = 1; d <= 9; d++) begin
         if (milli_ext >= MULT_W'(weight * MULT_W'(d))) begin
            digit = 4'(d);
         end
      end
      sub_val = MULT_W'(weight * MULT_W'(digit));
   end

   always_comb begin
      case (idx_ff)
         POS_HUNDREDS: next_char = CHAR_ZERO + CHAR_W'(dig_ff[5]);
         POS_TENS:     next_char = CHAR_ZERO + CHAR_W'(dig_ff[4]);
         POS_UNITS:    next_char = CHAR_ZERO + CHAR_W'(dig_ff[3]);
         POS_DOT:      next_char = CHAR_DOT;
         POS_FRAC0:    next_char = CHAR_ZERO + CHAR_W'(dig_ff[2]);
         POS_FRAC1:    next_char = CHAR_ZERO + CHAR_W'(dig_ff[1]);
         POS_FRAC2:    next_char = CHAR_ZERO + CHAR_W'(dig_ff[0]);
         POS_O:        next_char = CHAR_O;
         POS_C:        next_char = CHAR_C;
         POS_CR:       next_char = CHAR_CR;
         default:      next_char = CHAR_LF;
      endcase
   end

   assign load = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_ch.ready);
   assign pop = (state_ff == ST_IDLE) && !q_stat.empty;

   always_comb begin
      state_in = state_ff;
      milli_in = milli_ff;
      step_in = step_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            milli_in = MILLI_W'(product >> SCALE_SHIFT);
            step_in = 3'd0;
            state_in = ST_CONV;
         end
         ST_CONV: begin
            milli_in = MILLI_W'(milli_ext - sub_val);
            step_in = step_ff + 3'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_SEND;
               if (dig_ff[5] != 4'd0) begin
                  idx_in = POS_HUNDREDS;
               end else if (dig_ff[4] != 4'd0) begin
                  idx_in = POS_TENS;
               end else begin
                  idx_in = POS_UNITS;
               end
            end
         end
         ST_SEND: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               idx_in = idx_ff + 4'd1;
               if (idx_ff == POS_LF) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      milli_ff <= milli_in;
      step_ff <= step_in;
      idx_ff <= idx_in;
      if (pop) begin
         code_ff <= head_code;
      end
      if (state_ff == ST_CONV) begin
         dig_ff[dig_sel] <= digit;
         if (step_ff == LAST_STEP) begin
            dig_ff[0] <= 4'(milli_ext - sub_val);
         end
      end
      if (load) begin
         tx_char_ff <= next_char;
         last_ff <= (idx_ff == POS_LF);
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.tx_char = tx_char_ff;
   assign rsp_ch.last = last_ff;

`ifndef SYNTH
   a_last_is_lf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && last_ff) |-> (tx_char_ff == CHAR_LF))
      else $error("reply ends on a character other than LF");
   a_send_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> (idx_ff <= POS_LF))
      else $error("reply character position out of range");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_MUL))
      else $error("query taken without starting a conversion");
`endif

endmodule

FILE: rtl/core/temp_command_responder_top.sv
// Top level of the temperature command responder: line collector, query
// queue and reply generator. Uses tcr_pkg, tcr_req_if and tcr_rsp_if.
`timescale 1ns / 1ps

// The block takes one received byte per cycle on req_ch, each with the latest
// ADC code, while the two-entry query queue has room; a CR or LF ending a line
// that starts with "temp" queues the code present with it. The reply generator
// handles one query at a time: it takes it in ST_IDLE, does the multiply in
// ST_MUL, forms the decimal digits in ST_CONV (one digit per cycle), then sends
// one reply character per cycle on rsp_ch while the sink is ready; a reply has
// 9 to 11 characters. Bytes are stalled only when two queries already wait in
// the queue.
module temp_command_responder_top #(
   parameter int LINE_LEN = 8
) (
   input  logic       clock,
   input  logic       reset,
   tcr_req_if.sink    req_ch,
   tcr_rsp_if.source  rsp_ch
);
   import tcr_pkg::*;

   cmd_type           cmd;
   q_status_type      q_stat;
   logic              pop;
   logic [CODE_W-1:0] head_code;

   tcr_front #(
      .LINE_LEN (LINE_LEN)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_stat (q_stat),
      .cmd    (cmd)
   );

   tcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .pop       (pop),
      .q_stat    (q_stat),
      .head_code (head_code)
   );

   tcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_code (head_code),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: bench/tcr_reply_scoreboard.sv
// Scoreboard of the temperature command responder: watches both channels, predicts
// the reply characters of each line and compares them in order.
// Depends on tcr_pkg, tcr_req_if and tcr_rsp_if.
`timescale 1ns / 1ps

module tcr_reply_scoreboard #(
   parameter int LINE_LEN = 8
) (
   input  logic clock,
   input  logic reset,
   tcr_req_if   req_mon,
   tcr_rsp_if   rsp_mon,
   output int   mismatches,
   output int   chars_due
);
   import tcr_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] tx_char;
      logic              last;
   } reply_char_type;

   reply_char_type    reply_due[$];
   reply_char_type    due;
   logic [CHAR_W-1:0] line_start[PREFIX_DEPTH];
   int unsigned       line_len;

   function automatic void owe_char(input logic [CHAR_W-1:0] ch, input logic fin);
      reply_due.push_back('{tx_char: ch, last: fin});
   endfunction

   // Updates the line state with one received byte and queues the reply it causes.
   task automatic take_rx_byte(input logic [CHAR_W-1:0] ch, input logic [CODE_W-1:0] code);
      logic [63:0] milli;
      int unsigned whole;
      int unsigned frac;
      if (ch == CHAR_CR || ch == CHAR_LF) begin
         if (line_len >= PREFIX_DEPTH && line_start[0] == CHAR_T && line_start[1] == CHAR_E
             && line_start[2] == CHAR_M && line_start[3] == CHAR_P) begin
            // 106500 / 2^15 millidegrees per code step, product kept at full width.
            milli = (64'(code) * 64'd106500) >> 15;
            whole = int'(milli / 1000);
            frac = int'(milli % 1000);
            if (whole >= 100) owe_char(8'(CHAR_ZERO + whole / 100), 1'b0);
            if (whole >= 10) owe_char(8'(CHAR_ZERO + (whole / 10) % 10), 1'b0);
            owe_char(8'(CHAR_ZERO + whole % 10), 1'b0);
            owe_char(CHAR_DOT, 1'b0);
            owe_char(8'(CHAR_ZERO + frac / 100), 1'b0);
            owe_char(8'(CHAR_ZERO + (frac / 10) % 10), 1'b0);
            owe_char(8'(CHAR_ZERO + frac % 10), 1'b0);
            owe_char(CHAR_O, 1'b0);
            owe_char(CHAR_C, 1'b0);
            owe_char(CHAR_CR, 1'b0);
            owe_char(CHAR_LF, 1'b1);
         end
         line_len = 0;
      end else if (line_len < LINE_LEN - 1) begin
         if (line_len < PREFIX_DEPTH) line_start[line_len] = ch;
         line_len++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         line_len = 0;
         reply_due.delete();
         mismatches <= 0;
         chars_due <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reply_due.size() == 0) begin
               $display("%0t: reply char %02h last %0b with none expected", $time,
                        rsp_mon.tx_char, rsp_mon.last);
               mismatches <= mismatches + 1;
            end else begin
               due = reply_due.pop_front();
               if (due.tx_char !== rsp_mon.tx_char || due.last !== rsp_mon.last) begin
                  $display("%0t: reply char expected %02h last %0b, got %02h last %0b",
                           $time, due.tx_char, due.last, rsp_mon.tx_char, rsp_mon.last);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) take_rx_byte(req_mon.rx_byte, req_mon.adc_code);
         chars_due <= reply_due.size();
      end
   end

endmodule

FILE: bench/testbench.sv
// Top of the temperature command responder bench: clock, reset, byte stimulus and
// reply sink with random stalls. Depends on tcr_pkg, the channel interfaces,
// temp_command_responder_top and tcr_reply_scoreboard.
`timescale 1ns / 1ps

module testbench;
   import tcr_pkg::*;

   localparam int LINE_LEN = 8;
   localparam int BYTES_TOTAL = 380;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [31:0] QUERY_WORD = {CHAR_T, CHAR_E, CHAR_M, CHAR_P};

   logic clock;
   logic reset;
   logic steady;
   int   mismatches;
   int   chars_due;
   int   bytes_sent;
   int   quiet_cycles;

   tcr_req_if req_ch();
   tcr_rsp_if rsp_ch();

   temp_command_responder_top #(.LINE_LEN(LINE_LEN)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   tcr_reply_scoreboard #(.LINE_LEN(LINE_LEN)) scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .mismatches (mismatches),
      .chars_due  (chars_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [CODE_W-1:0] pick_code();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CODE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] plain_byte();
      logic [CHAR_W-1:0] b;
      do b = CHAR_W'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   // One transfer on the byte channel, with a random gap before it outside the steady stretch.
   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic [CODE_W-1:0] code);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 22) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= ch;
      req_ch.adc_code <= code;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      steady = (bytes_sent >= 150 && bytes_sent < 260);
   endtask

   task automatic send_text(input string text, input logic [CHAR_W-1:0] term,
                            input logic [CODE_W-1:0] code);
      for (int i = 0; i < text.len(); i++) send_char(text[i], code);
      send_char(term, code);
   endtask

   task automatic send_random_line();
      logic [CHAR_W-1:0] line[$];
      logic [CODE_W-1:0] code;
      int kind;
      int pos;
      code = pick_code();
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         for (pos = 0; pos < 4; pos++) line.push_back(QUERY_WORD[31 - 8 * pos -: 8]);
         // A share of the queries gets one prefix character spoiled.
         if (kind >= 60) line[$urandom_range(0, 3)] = plain_byte();
         repeat ($urandom_range(0, 6)) line.push_back(plain_byte());
         line.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else if (kind < 88) begin
         for (pos = 0; pos < $urandom_range(0, 3); pos++)
            line.push_back($urandom_range(0, 1) ? QUERY_WORD[31 - 8 * pos -: 8] : plain_byte());
         line.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else begin
         repeat ($urandom_range(1, 10)) line.push_back(CHAR_W'($urandom_range(0, 255)));
      end
      foreach (line[k]) send_char(line[k], ($urandom_range(0, 3) == 0) ? pick_code() : code);
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 22);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      req_ch.adc_code = '0;
      steady = 1'b0;
      bytes_sent = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest and largest codes, a short and an empty line, and an overlong line.
      send_text("temp", CHAR_CR, '0);
      send_text("temp", CHAR_LF, '1);
      send_text("tem", CHAR_CR, 16'd20000);
      send_text("", CHAR_LF, 16'd0);
      send_text("temp1234", CHAR_CR, 16'd10000);

      while (bytes_sent < BYTES_TOTAL) send_random_line();
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (chars_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/tcr_pkg.sv
rtl/core/tcr_channels.sv
rtl/core/tcr_front.sv
rtl/core/tcr_queue.sv
rtl/core/tcr_back.sv
rtl/core/temp_command_responder_top.sv
bench/tcr_reply_scoreboard.sv
bench/testbench.sv
